@@ rtl/bts_pkg.sv @@
// shared types and constants for the bitmap to region scanner
package bts_pkg;

   // default for the longest row, in words
   localparam int MAX_ROW_WORDS_DEFAULT = 256;

   // value carried by an end marker
   localparam logic [15:0] END_MARK = 16'd32767;

   // result tags
   localparam logic [1:0] TAG_ROW   = 2'd0;
   localparam logic [1:0] TAG_COORD = 2'd1;
   localparam logic [1:0] TAG_END   = 2'd2;

   // configuration register indexes
   localparam logic CSR_LEFT_EDGE   = 1'b0;
   localparam logic CSR_MARGIN_BITS = 1'b1;

   // pending results of one input word, drained one per cycle while rsp is ready
   typedef struct packed {
      logic        row_pend;   // row number still to send
      logic [15:0] row_val;
      logic [15:0] base;       // coordinate of the word's leftmost pixel
      logic [15:0] flips;      // parity flip positions, bit 15 leftmost
      logic        close_pend; // closing coordinate still to send
      logic [15:0] close_val;
      logic        end_pend;   // row end marker still to send
      logic        fin_pend;   // finish end marker still to send
   } bts_desc_type;

endpackage

@@ rtl/bts_emitter.sv @@
// result sequencer: holds one word's pending results and sends them in order
module bts_emitter (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load_valid,
   output logic                  load_ready,
   input  bts_pkg::bts_desc_type load_desc,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [15:0]           rsp_tdata,  // value
   output logic [1:0]            rsp_tuser,  // tag
   output logic                  rsp_tlast
);

   logic                  valid_ff, valid_in;
   bts_pkg::bts_desc_type desc_ff, desc_in;
   bts_pkg::bts_desc_type desc_rest;
   logic [3:0]            lead;
   logic [3:0]            lead_pos;
   logic                  fire;

   // highest set flip bit is the leftmost pixel
   always_comb begin
      lead = 4'd0;
      for (int i = 0; i < 16; i++) begin
         if (desc_ff.flips[i]) begin
            lead = 4'(i);
         end
      end
      lead_pos = 4'd15 - lead;
   end

   // pick the current result and what stays pending after it
   always_comb begin
      desc_rest = desc_ff;
      rsp_tdata = bts_pkg::END_MARK;
      rsp_tuser = bts_pkg::TAG_END;
      if (desc_ff.row_pend) begin
         rsp_tdata          = desc_ff.row_val;
         rsp_tuser          = bts_pkg::TAG_ROW;
         desc_rest.row_pend = 1'b0;
      end else if (desc_ff.flips != 16'd0) begin
         rsp_tdata             = desc_ff.base + {12'd0, lead_pos};
         rsp_tuser             = bts_pkg::TAG_COORD;
         desc_rest.flips[lead] = 1'b0;
      end else if (desc_ff.close_pend) begin
         rsp_tdata            = desc_ff.close_val;
         rsp_tuser            = bts_pkg::TAG_COORD;
         desc_rest.close_pend = 1'b0;
      end else if (desc_ff.end_pend) begin
         desc_rest.end_pend = 1'b0;
      end else begin
         desc_rest.fin_pend = 1'b0;
      end
   end

   assign rsp_tlast  = !desc_rest.row_pend && (desc_rest.flips == 16'd0) &&
                       !desc_rest.close_pend && !desc_rest.end_pend &&
                       !desc_rest.fin_pend;
   assign rsp_tvalid = valid_ff;
   assign fire       = valid_ff && rsp_tready;
   assign load_ready = !valid_ff || (rsp_tready && rsp_tlast);

   // next descriptor: new word, drained remainder or hold
   always_comb begin
      valid_in = valid_ff;
      desc_in  = desc_ff;
      if (load_ready) begin
         valid_in = load_valid;
         desc_in  = load_desc;
      end else if (fire) begin
         desc_in = desc_rest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      desc_ff <= desc_in;
   end

endmodule

@@ rtl/bitmap_to_region_scanner.sv @@
// top level of the bitmap to region scanner
//
//  channel | direction | tdata                         | tuser | tlast
//  req     | in        | row_v, cur_word, prev_word    | kind  | last_word
//  rsp     | out       | value                         | tag   | last
//  csr     | in        | write enable, index, data     | -     | -
//
// a word is scanned in the cycle it is accepted; its results follow from the
// next cycle on, one per cycle while rsp is ready, from a single descriptor register.
// a word that causes any result causes 1 to 19 of them;
// a word that causes no result is never queued.
// reset (synchronous) clears the row position, parity and pending results.
// req waits while results are pending and is taken in the cycle the last one goes out;
// a stall on rsp holds the current result and holds req with it.
module bitmap_to_region_scanner #(
   parameter int MAX_ROW_WORDS = bts_pkg::MAX_ROW_WORDS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // row_v[15:0], cur_word[31:16], prev_word[47:32]
   input  logic        req_tuser,  // kind
   input  logic        req_tlast,  // last_word
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // value
   output logic [1:0]  rsp_tuser,  // tag
   output logic        rsp_tlast,  // last
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [15:0] csr_wdata
);

   localparam int IDX_W = (MAX_ROW_WORDS > 1) ? $clog2(MAX_ROW_WORDS) : 1;
   localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_ROW_WORDS - 1);

   logic [15:0]      left_edge_ff;
   logic [3:0]       margin_bits_ff;
   logic [IDX_W-1:0] word_index_ff, word_index_in;
   logic             run_parity_ff, run_parity_in;
   logic             row_started_ff, row_started_in;

   logic [15:0]      row_v, cur_word, prev_word;
   logic [15:0]      diff, flips;
   logic             started_new, has_results, accept;
   logic             load_ready;
   logic [15:0]      word_off, next_off;
   bts_pkg::bts_desc_type desc;

   assign row_v     = req_tdata[15:0];
   assign cur_word  = req_tuser ? 16'd0 : req_tdata[31:16];
   assign prev_word = req_tdata[47:32];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         left_edge_ff   <= 16'd0;
         margin_bits_ff <= 4'd0;
      end else if (csr_we) begin
         unique case (csr_addr)
            bts_pkg::CSR_LEFT_EDGE:   left_edge_ff   <= csr_wdata;
            bts_pkg::CSR_MARGIN_BITS: margin_bits_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // changed pixels, margin masked on the row's last word
   always_comb begin
      diff = cur_word ^ prev_word;
      if (req_tlast) begin
         diff = diff & (16'hFFFF << margin_bits_ff);
      end
      flips = diff ^ {run_parity_ff, diff[15:1]};
   end

   assign word_off = 16'(32'(word_index_ff) << 4);
   assign next_off = 16'((32'(word_index_ff) + 32'd1) << 4);

   // descriptor of this word's results
   assign started_new = row_started_ff || (flips != 16'd0);
   always_comb begin
      desc.row_pend   = !row_started_ff && (flips != 16'd0);
      desc.row_val    = row_v;
      desc.base       = left_edge_ff + word_off;
      desc.flips      = flips;
      desc.close_pend = req_tlast && started_new && diff[0];
      desc.close_val  = left_edge_ff + next_off;
      desc.end_pend   = req_tlast && started_new;
      desc.fin_pend   = req_tlast && req_tuser;
   end
   assign has_results = (flips != 16'd0) || desc.end_pend || desc.fin_pend;

   assign req_tready = load_ready;
   assign accept     = req_tvalid && load_ready;

   // row scan state
   always_comb begin
      word_index_in  = word_index_ff;
      run_parity_in  = run_parity_ff;
      row_started_in = row_started_ff;
      if (accept) begin
         if (req_tlast) begin
            word_index_in  = '0;
            run_parity_in  = 1'b0;
            row_started_in = 1'b0;
         end else begin
            if (word_index_ff < IDX_MAX) begin
               word_index_in = word_index_ff + IDX_W'(1);
            end
            run_parity_in  = diff[0];
            row_started_in = started_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_index_ff  <= '0;
         run_parity_ff  <= 1'b0;
         row_started_ff <= 1'b0;
      end else begin
         word_index_ff  <= word_index_in;
         run_parity_ff  <= run_parity_in;
         row_started_ff <= row_started_in;
      end
   end

   // result sequencer
   bts_emitter u_emitter (
      .clock      (clock),
      .reset      (reset),
      .load_valid (accept && has_results),
      .load_ready (load_ready),
      .load_desc  (desc),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // an empty sequencer always takes a word
   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req_tready low while no result pending");

   // a word's results come out without gaps until its last
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("result run broken before last");

   // a row number is always followed by a coordinate
   a_row_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == bts_pkg::TAG_ROW) |-> !rsp_tlast)
      else $error("row number sent as last result");

   // word position saturates
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      word_index_ff <= IDX_MAX)
      else $error("word index beyond row length");

endmodule

@@ dv/tb_bitmap_to_region_scanner.sv @@
// testbench for the bitmap to region scanner: directed and random row words, scored result words
module tb_bitmap_to_region_scanner;

   localparam int MAX_WORDS   = bts_pkg::MAX_ROW_WORDS_DEFAULT;
   localparam int CYCLE_LIMIT = 400000;

   // one row word as presented on req
   typedef struct packed {
      logic        kind;
      logic [15:0] row_v;
      logic [15:0] cur_word;
      logic [15:0] prev_word;
      logic        last_word;
      logic        drain;      // hold this word until all results are in
   } row_word_type;

   // one result word as seen on rsp
   typedef struct packed {
      logic [15:0] value;
      logic [1:0]  tag;
      logic        last;
   } point_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic        csr_addr = 1'b0;
   logic [15:0] csr_wdata = '0;

   bitmap_to_region_scanner dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   row_word_type word_feed[$];
   point_type    region_points[$];
   int           words_queued = 0;
   int           words_taken = 0;
   int           fail_count = 0;
   int           cycle_count = 0;
   bit           no_idle = 1'b0;

   // scanner state mirror
   logic [15:0] row_left = '0;
   logic [3:0]  margin_width = '0;
   int          row_word_pos = 0;
   logic        xor_level = 1'b0;
   logic        row_open = 1'b0;

   // inversion points caused by one accepted row word
   task automatic scan_row_word(input row_word_type w);
      logic [15:0] cur_bits;
      logic [15:0] diff;
      logic [15:0] base;
      point_type   batch[$];
      cur_bits = w.kind ? 16'h0000 : w.cur_word;
      diff = cur_bits ^ w.prev_word;
      base = row_left + 16'(row_word_pos * 16);
      // margin only trims the last word of a row
      if (w.last_word)
         diff = diff & ~((16'd1 << margin_width) - 16'd1);
      for (int b = 15; b >= 0; b--) begin
         if (diff[b] != xor_level) begin
            if (!row_open) begin
               batch.push_back({w.row_v, bts_pkg::TAG_ROW, 1'b0});
               row_open = 1'b1;
            end
            batch.push_back({base + 16'(15 - b), bts_pkg::TAG_COORD, 1'b0});
            xor_level = ~xor_level;
         end
      end
      if (w.last_word) begin
         if (row_open) begin
            // closing point uses the full word width
            if (xor_level)
               batch.push_back({row_left + 16'((row_word_pos + 1) * 16),
                                bts_pkg::TAG_COORD, 1'b0});
            batch.push_back({bts_pkg::END_MARK, bts_pkg::TAG_END, 1'b0});
         end
         if (w.kind)
            batch.push_back({bts_pkg::END_MARK, bts_pkg::TAG_END, 1'b0});
         row_word_pos = 0;
         xor_level = 1'b0;
         row_open = 1'b0;
      end else if (row_word_pos < MAX_WORDS - 1) begin
         row_word_pos++;
      end
      if (batch.size() != 0)
         batch[batch.size() - 1].last = 1'b1;
      foreach (batch[i])
         region_points.push_back(batch[i]);
   endtask

   function automatic int draw_gap();
      return no_idle ? 0 : $urandom_range(0, 10);
   endfunction

   task automatic queue_word(input logic kind, input logic [15:0] row_v,
                             input logic [15:0] cur_word, input logic [15:0] prev_word,
                             input logic last_word, input bit drain);
      word_feed.push_back({kind, row_v, cur_word, prev_word, last_word, drain});
      words_queued++;
   endtask

   // sender: presents queued words with random gaps
   row_word_type active_word;
   row_word_type next_word;
   int           send_gap = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            scan_row_word(active_word);
            words_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap != 0) begin
               send_gap <= send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (word_feed.size() != 0 &&
                         (!word_feed[0].drain || region_points.size() == 0)) begin
               next_word = word_feed.pop_front();
               active_word = next_word;
               req_tdata <= {next_word.prev_word, next_word.cur_word, next_word.row_v};
               req_tuser <= next_word.kind;
               req_tlast <= next_word.last_word;
               req_tvalid <= 1'b1;
               send_gap <= draw_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver: scores each result word and stalls at random
   point_type got_point;
   point_type want_point;
   int        stall_left = 0;
   int        stall_draw;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         got_point = {rsp_tdata, rsp_tuser, rsp_tlast};
         if (region_points.size() == 0) begin
            $error("unexpected result word: value %0d tag %0d last %0d",
                   $signed(got_point.value), got_point.tag, got_point.last);
            fail_count++;
         end else begin
            want_point = region_points.pop_front();
            if (got_point.value !== want_point.value) begin
               $error("value mismatch: expected %0d actual %0d",
                      $signed(want_point.value), $signed(got_point.value));
               fail_count++;
            end
            if (got_point.tag !== want_point.tag) begin
               $error("tag mismatch: expected %0d actual %0d", want_point.tag, got_point.tag);
               fail_count++;
            end
            if (got_point.last !== want_point.last) begin
               $error("last mismatch: expected %0d actual %0d", want_point.last, got_point.last);
               fail_count++;
            end
         end
         stall_draw = draw_gap();
         stall_left <= stall_draw;
         rsp_tready <= (stall_draw == 0);
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= (stall_left == 1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_bitmap_to_region_scanner NOT OK");
         $finish;
      end
   end

   // block is idle once every word is taken and every result is in
   task automatic wait_idle();
      while (words_taken != words_queued || region_points.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic addr, input logic [15:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (addr == bts_pkg::CSR_LEFT_EDGE)
         row_left = data;
      else
         margin_width = data[3:0];
   endtask

   // well-formed rows with random content, plus some stray words
   task automatic add_random_words(input int target);
      int          added;
      int          len;
      int          mode;
      logic        fin;
      logic [15:0] row;
      logic [15:0] cur;
      logic [15:0] same;
      logic [15:0] prev;
      added = 0;
      while (added < target) begin
         if ($urandom_range(0, 99) < 15) begin
            queue_word(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
                       16'($urandom), 1'($urandom_range(0, 1)), $urandom_range(0, 49) == 0);
            added++;
         end else begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
            fin = ($urandom_range(0, 4) == 0);
            row = 16'($urandom);
            for (int i = 0; i < len; i++) begin
               // row number may change in the middle of a row
               if ($urandom_range(0, 9) == 0)
                  row = 16'($urandom);
               cur = 16'($urandom);
               same = fin ? 16'h0000 : cur;
               mode = $urandom_range(0, 9);
               if (mode < 4)
                  prev = same;
               else if (mode < 6)
                  prev = 16'($urandom);
               else if (mode < 8)
                  prev = same ^ (16'd1 << $urandom_range(0, 15));
               else
                  prev = same ^ 16'($urandom & $urandom & $urandom);
               queue_word(fin, row, cur, prev, i == len - 1,
                          i == 0 && $urandom_range(0, 19) == 0);
            end
            added += len;
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // phase 0: default placement, no margin
      write_csr(bts_pkg::CSR_LEFT_EDGE, 16'h0000);
      write_csr(bts_pkg::CSR_MARGIN_BITS, 16'h0000);
      // unchanged row stays silent
      queue_word(1'b0, 16'd3, 16'hA5A5, 16'hA5A5, 1'b1, 1'b1);
      queue_word(1'b0, 16'h8000, 16'hFFFF, 16'h0000, 1'b1, 1'b0);
      queue_word(1'b0, 16'h7FFF, 16'h0000, 16'hFFFF, 1'b1, 1'b0);
      queue_word(1'b0, 16'd1, 16'h8001, 16'h0000, 1'b1, 1'b0);
      // a flip at every pixel
      queue_word(1'b0, 16'd2, 16'hAAAA, 16'h0000, 1'b1, 1'b0);
      // finish word on an unchanged row gives only its own end marker
      queue_word(1'b1, 16'd4, 16'hFFFF, 16'h0000, 1'b1, 1'b0);
      queue_word(1'b1, 16'd6, 16'h1234, 16'h5555, 1'b1, 1'b0);
      // row number taken from the word with the first change
      queue_word(1'b0, 16'd5, 16'h1111, 16'h1111, 1'b0, 1'b0);
      queue_word(1'b0, 16'hFFF9, 16'h00FF, 16'h0000, 1'b0, 1'b0);
      queue_word(1'b0, 16'd9, 16'h0000, 16'h0000, 1'b1, 1'b0);
      // odd level carried into the closing point
      queue_word(1'b0, 16'd10, 16'h0001, 16'h0000, 1'b0, 1'b0);
      queue_word(1'b0, 16'd10, 16'hFFFF, 16'h0000, 1'b1, 1'b0);
      // finish word in the middle of a row
      queue_word(1'b1, 16'd11, 16'hFFFF, 16'h0F00, 1'b0, 1'b1);
      queue_word(1'b0, 16'd11, 16'h0000, 16'h0000, 1'b1, 1'b0);
      add_random_words(30);
      wait_idle();

      // phase 1: top of the range, widest margin
      write_csr(bts_pkg::CSR_LEFT_EDGE, 16'h7FFF);
      write_csr(bts_pkg::CSR_MARGIN_BITS, 16'h000F);
      queue_word(1'b0, 16'd20, 16'hFFFF, 16'h0000, 1'b1, 1'b1);
      queue_word(1'b0, 16'd21, 16'h7FFF, 16'h0000, 1'b1, 1'b0);
      queue_word(1'b0, 16'd22, 16'h0001, 16'h0000, 1'b0, 1'b0);
      queue_word(1'b0, 16'd22, 16'h1234, 16'h1234, 1'b1, 1'b0);
      queue_word(1'b1, 16'd23, 16'h0000, 16'h0001, 1'b1, 1'b0);
      add_random_words(30);
      wait_idle();

      // phase 2: bottom of the range, back-to-back traffic
      write_csr(bts_pkg::CSR_LEFT_EDGE, 16'h8000);
      write_csr(bts_pkg::CSR_MARGIN_BITS, 16'h0000);
      no_idle = 1'b1;
      add_random_words(30);
      wait_idle();
      no_idle = 1'b0;

      // phase 3: random placement, plus one row long enough to saturate
      write_csr(bts_pkg::CSR_LEFT_EDGE, 16'($urandom));
      write_csr(bts_pkg::CSR_MARGIN_BITS, 16'($urandom_range(0, 15)));
      add_random_words(20);
      for (int i = 0; i < MAX_WORDS + 8; i++) begin
         automatic logic [15:0] fill = 16'($urandom);
         queue_word(1'b0, 16'd77, fill,
                    (i == 40 || i == MAX_WORDS + 2) ? fill ^ 16'h0100 : fill,
                    i == MAX_WORDS + 7, i == 0);
      end
      add_random_words(20);
      wait_idle();

      // phase 4: near the top of the unsigned range, mid margin
      write_csr(bts_pkg::CSR_LEFT_EDGE, 16'hFFF0);
      write_csr(bts_pkg::CSR_MARGIN_BITS, 16'h0007);
      add_random_words(20);
      wait_idle();
      no_idle = 1'b1;
      add_random_words(20);
      wait_idle();

      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("tb_bitmap_to_region_scanner OK");
      else
         $display("tb_bitmap_to_region_scanner NOT OK");
      $finish;
   end

endmodule

@@ files.f @@
rtl/bts_pkg.sv
rtl/bts_emitter.sv
rtl/bitmap_to_region_scanner.sv
dv/tb_bitmap_to_region_scanner.sv
